>>> rtl/core/vbae_pkg.sv
// Shared widths, constants and controller/datapath interface structs.
`timescale 1ns / 1ps
package vbae_pkg;

    localparam int MAX_BRICKS_PER_AXIS = 32;
    localparam int BRICK_EDGE          = 8;
    localparam int VOXELS_IN_BRICK     = 512;
    localparam int EDGE_BITS           = $clog2(BRICK_EDGE);
    localparam int LOCAL_W             = $clog2(VOXELS_IN_BRICK);
    localparam int DIV_W               = $clog2(MAX_BRICKS_PER_AXIS + 1);
    localparam int MAP_AW              = 15;
    localparam int MAP_DEPTH           = 1 << MAP_AW;
    localparam int MAP_W               = MAP_AW + 1;
    localparam int CNT_W               = 16;
    localparam int DIV_STEPS           = CNT_W;
    localparam int STEP_W              = $clog2(DIV_STEPS);
    localparam int COORD_W             = 40;
    localparam int UNIT_W              = CNT_W + EDGE_BITS;
    localparam int PROD_W              = UNIT_W + 32;

    localparam logic [2:0] REG_BRICKS_PER_AXIS = 3'd0;
    localparam logic [2:0] REG_BRICK_COUNT     = 3'd1;
    localparam logic [2:0] REG_VOXEL_SIZE      = 3'd2;
    localparam logic [2:0] REG_LOOKUP_ENABLE   = 3'd3;

    typedef struct packed {
        logic cap;
        logic clr_wr;
        logic ld_rd;
        logic ld_wr;
        logic map_chk;
        logic lin_start;
        logic div_step;
        logic div_a_end;
        logic div_b_end;
        logic vox_adv;
        logic mul_x;
        logic mul_y;
        logic mul_z;
        logic mul_end;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_mode1;
        logic in_lookup_ok;
        logic exhausted;
        logic first_voxel;
        logic lookup_en;
        logic map_found;
        logic solid;
        logic div_last;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/core/voxel_brick_aabb_emitter.sv
// Top level of the voxel brick box emitter.
//   channel | signals                              | direction
//   in      | in_valid/in_ready + input fields     | request in
//   cfg     | cfg_valid/cfg_ready, index, data     | register write in
//   out     | out_valid/out_ready + box fields     | request out
// Map load: reads then writes the map entry; dropped when its brick number is out of range.
// Voxel request: dropped past the last brick; a solid voxel goes on through the multiplier.
// The first voxel of a brick first runs the bit-serial coordinate divider twice, after a map
// read when lookup is on (only the map read when the brick is not in the map).
// Reset clears the 32768-entry inverse map; requests wait, config writes pass.
// A result waits in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps
module voxel_brick_aabb_emitter
    import vbae_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   mode,
    input  logic [MAP_AW-1:0]      grid_index,
    input  logic [31:0]            lookup_value,
    input  logic [31:0]            material_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_W-1:0]     min_x,
    output logic [COORD_W-1:0]     min_y,
    output logic [COORD_W-1:0]     min_z,
    output logic [COORD_W-1:0]     max_x,
    output logic [COORD_W-1:0]     max_y,
    output logic [COORD_W-1:0]     max_z,
    output logic [31:0]            material_id,
    output logic [MAP_AW-1:0]      brick_number,
    output logic [LOCAL_W-1:0]     local_index
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    vbae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vbae_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .grid_index    (grid_index),
        .lookup_value  (lookup_value),
        .material_word (material_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .min_x         (min_x),
        .min_y         (min_y),
        .min_z         (min_z),
        .max_x         (max_x),
        .max_y         (max_y),
        .max_z         (max_z),
        .material_id   (material_id),
        .brick_number  (brick_number),
        .local_index   (local_index)
    );

endmodule

>>> rtl/core/vbae_ctrl.sv
// Controller state machine sequencing map clearing and updates, coordinate division and box output.
`timescale 1ns / 1ps
module vbae_ctrl
    import vbae_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [15:0] {
        S_CLEAR     = 16'h0001,
        S_IDLE      = 16'h0002,
        S_LD_RD     = 16'h0004,
        S_LD_WR     = 16'h0008,
        S_MAP_RD    = 16'h0010,
        S_MAP_CHK   = 16'h0020,
        S_DIV_A     = 16'h0040,
        S_DIV_A_END = 16'h0080,
        S_DIV_B     = 16'h0100,
        S_DIV_B_END = 16'h0200,
        S_VOX       = 16'h0400,
        S_MUL_X     = 16'h0800,
        S_MUL_Y     = 16'h1000,
        S_MUL_Z     = 16'h2000,
        S_MUL_END   = 16'h4000,
        S_EMIT      = 16'h8000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap = 1'b1;
                    if (!sts.in_mode1)
                    begin
                        if (sts.in_lookup_ok)
                        begin
                            state_next = S_LD_RD;
                        end
                    end
                    else if (!sts.exhausted)
                    begin
                        if (!sts.first_voxel)
                        begin
                            state_next = S_VOX;
                        end
                        else if (sts.lookup_en)
                        begin
                            state_next = S_MAP_RD;
                        end
                        else
                        begin
                            cmd.lin_start = 1'b1;
                            state_next    = S_DIV_A;
                        end
                    end
                end
            end
            S_LD_RD:
            begin
                cmd.ld_rd  = 1'b1;
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                cmd.ld_wr  = 1'b1;
                state_next = S_IDLE;
            end
            S_MAP_RD:
            begin
                state_next = S_MAP_CHK;
            end
            S_MAP_CHK:
            begin
                cmd.map_chk = 1'b1;
                state_next  = sts.map_found ? S_DIV_A : S_VOX;
            end
            S_DIV_A:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DIV_A_END;
                end
            end
            S_DIV_A_END:
            begin
                cmd.div_a_end = 1'b1;
                state_next    = S_DIV_B;
            end
            S_DIV_B:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DIV_B_END;
                end
            end
            S_DIV_B_END:
            begin
                cmd.div_b_end = 1'b1;
                state_next    = S_VOX;
            end
            S_VOX:
            begin
                cmd.vox_adv = 1'b1;
                state_next  = sts.solid ? S_MUL_X : S_IDLE;
            end
            S_MUL_X:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                cmd.mul_y  = 1'b1;
                state_next = S_MUL_Z;
            end
            S_MUL_Z:
            begin
                cmd.mul_z  = 1'b1;
                state_next = S_MUL_END;
            end
            S_MUL_END:
            begin
                cmd.mul_end = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/vbae_dp.sv
// Datapath: config registers, inverse map memory, divider, multiplier and output register.
`timescale 1ns / 1ps
module vbae_dp
    import vbae_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic                   cfg_valid,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   mode,
    input  logic [MAP_AW-1:0]      grid_index,
    input  logic [31:0]            lookup_value,
    input  logic [31:0]            material_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_W-1:0]     min_x,
    output logic [COORD_W-1:0]     min_y,
    output logic [COORD_W-1:0]     min_z,
    output logic [COORD_W-1:0]     max_x,
    output logic [COORD_W-1:0]     max_y,
    output logic [COORD_W-1:0]     max_z,
    output logic [31:0]            material_id,
    output logic [MAP_AW-1:0]      brick_number,
    output logic [LOCAL_W-1:0]     local_index
);

    localparam logic [COORD_W-1:0] SAT = '1;

    logic [5:0]           bpa_reg;
    logic [15:0]          bcount_reg;
    logic [31:0]          vsize_reg;
    logic                 lken_reg;

    logic [MAP_W-1:0]     mem [MAP_DEPTH];
    logic [MAP_W-1:0]     rdata_reg;
    logic [MAP_AW-1:0]    raddr;
    logic                 we;
    logic [MAP_AW-1:0]    waddr;
    logic [MAP_W-1:0]     wdata;
    logic [MAP_AW-1:0]    clr_reg;

    logic [MAP_AW-1:0]    grid_reg;
    logic [MAP_AW-1:0]    bval_reg;
    logic [31:0]          mat_reg;

    logic [LOCAL_W-1:0]   vcnt_reg;
    logic [CNT_W-1:0]     bcnt_reg;
    logic                 found_reg;
    logic [LOCAL_W-1:0]   local_reg;
    logic [MAP_AW-1:0]    brick_reg;

    logic [DIV_W-1:0]     dvs;
    logic [CNT_W-1:0]     q_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIV_W:0]       trial;
    logic                 qbit;
    logic [DIV_W-1:0]     rem_step;

    logic [DIV_W-2:0]     cx_reg;
    logic [DIV_W-2:0]     cy_reg;
    logic [CNT_W-1:0]     cz_reg;

    logic [UNIT_W-1:0]    unit;
    logic [PROD_W-1:0]    prod_reg;
    logic [COORD_W-1:0]   sat_prod;
    logic [COORD_W-1:0]   mnx_reg;
    logic [COORD_W-1:0]   mny_reg;
    logic [COORD_W-1:0]   mnz_reg;

    function automatic logic [COORD_W-1:0] add_size(input logic [COORD_W-1:0] v,
                                                    input logic [31:0] s);
        logic [COORD_W:0] t;
        t = {1'b0, v} + {{(COORD_W - 31){1'b0}}, s};
        return t[COORD_W] ? SAT : t[COORD_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpa_reg    <= 6'd1;
            bcount_reg <= 16'd0;
            vsize_reg  <= 32'd65536;
            lken_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BRICKS_PER_AXIS: bpa_reg    <= cfg_data[5:0];
                REG_BRICK_COUNT:     bcount_reg <= cfg_data[15:0];
                REG_VOXEL_SIZE:      vsize_reg  <= cfg_data;
                REG_LOOKUP_ENABLE:   lken_reg   <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        if (bpa_reg == 6'd0)
        begin
            dvs = DIV_W'(1);
        end
        else if (bpa_reg > 6'(MAX_BRICKS_PER_AXIS))
        begin
            dvs = DIV_W'(MAX_BRICKS_PER_AXIS);
        end
        else
        begin
            dvs = DIV_W'(bpa_reg);
        end
    end

    assign raddr = cmd.ld_rd ? bval_reg : bcnt_reg[MAP_AW-1:0];
    assign we    = cmd.clr_wr
                 || (cmd.ld_wr && (!rdata_reg[MAP_AW] || grid_reg < rdata_reg[MAP_AW-1:0]));
    assign waddr = cmd.clr_wr ? clr_reg : bval_reg;
    assign wdata = cmd.clr_wr ? '0 : {1'b1, grid_reg};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            vcnt_reg  <= '0;
            bcnt_reg  <= '0;
            found_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.lin_start)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.map_chk)
            begin
                found_reg <= rdata_reg[MAP_AW];
            end
            if (cmd.vox_adv)
            begin
                if (vcnt_reg == LOCAL_W'(VOXELS_IN_BRICK - 1))
                begin
                    vcnt_reg <= '0;
                    bcnt_reg <= bcnt_reg + 1'b1;
                end
                else
                begin
                    vcnt_reg <= vcnt_reg + 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    assign trial    = {rem_reg, q_reg[CNT_W-1]};
    assign qbit     = (trial >= {1'b0, dvs});
    assign rem_step = qbit ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];

    always_comb
    begin
        case (1'b1)
            cmd.mul_x: unit = UNIT_W'({cx_reg, local_reg[EDGE_BITS-1:0]});
            cmd.mul_y: unit = UNIT_W'({cy_reg, local_reg[2*EDGE_BITS-1:EDGE_BITS]});
            default:   unit = {cz_reg, local_reg[3*EDGE_BITS-1:2*EDGE_BITS]};
        endcase
    end

    assign sat_prod = (prod_reg[PROD_W-1:COORD_W] != '0) ? SAT : prod_reg[COORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            grid_reg <= grid_index;
            bval_reg <= lookup_value[MAP_AW-1:0];
            mat_reg  <= material_word;
        end
        if (cmd.lin_start)
        begin
            q_reg    <= bcnt_reg;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (cmd.map_chk)
        begin
            q_reg    <= CNT_W'(rdata_reg[MAP_AW-1:0]);
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (cmd.div_step)
        begin
            q_reg    <= {q_reg[CNT_W-2:0], qbit};
            rem_reg  <= rem_step;
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.div_a_end)
        begin
            cx_reg   <= rem_reg[DIV_W-2:0];
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (cmd.div_b_end)
        begin
            cy_reg <= rem_reg[DIV_W-2:0];
            cz_reg <= q_reg;
        end
        if (cmd.vox_adv)
        begin
            local_reg <= vcnt_reg;
            brick_reg <= bcnt_reg[MAP_AW-1:0];
        end
        if (cmd.mul_x || cmd.mul_y || cmd.mul_z)
        begin
            prod_reg <= PROD_W'(unit) * PROD_W'(vsize_reg);
        end
        if (cmd.mul_y)
        begin
            mnx_reg <= sat_prod;
        end
        if (cmd.mul_z)
        begin
            mny_reg <= sat_prod;
        end
        if (cmd.mul_end)
        begin
            mnz_reg <= sat_prod;
        end
        if (cmd.emit)
        begin
            min_x        <= mnx_reg;
            min_y        <= mny_reg;
            min_z        <= mnz_reg;
            max_x        <= add_size(mnx_reg, vsize_reg);
            max_y        <= add_size(mny_reg, vsize_reg);
            max_z        <= add_size(mnz_reg, vsize_reg);
            material_id  <= mat_reg;
            brick_number <= brick_reg;
            local_index  <= local_reg;
        end
    end

    always_comb
    begin
        sts.in_mode1     = mode;
        sts.in_lookup_ok = (lookup_value < 32'(MAP_DEPTH));
        sts.exhausted    = (bcnt_reg >= bcount_reg);
        sts.first_voxel  = (vcnt_reg == '0);
        sts.lookup_en    = lken_reg;
        sts.map_found    = rdata_reg[MAP_AW];
        sts.solid        = found_reg && (mat_reg != 32'd0);
        sts.div_last     = (step_reg == STEP_W'(DIV_STEPS - 1));
        sts.clr_last     = (clr_reg == MAP_AW'(MAP_DEPTH - 1));
        sts.out_free     = !out_valid || out_ready;
    end

endmodule
